[src/assert_macros.svh]
// Assertion macros shared by the RTL of the list search block.
// Uses the enclosing module's clk_i and rst_ni; bodies are empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SOLS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define SOLS_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SOLS_ASSERT(label, prop)
`define SOLS_NEVER(label, expr)
`endif

`endif

[src/sols_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// self-organising list search block. No dependencies.
package sols_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int KEY_W      = 32;
  localparam int POS_W      = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int MODE_W     = 2;
  localparam int LEN_W      = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

  localparam logic [CFG_DATA_W-1:0] LEN_RST = CFG_DATA_W'(256);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REORDER_MODE  = 1'b1;

  // reorder modes (code 3 behaves as none)
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRONT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP  = 2'd2;

  // word commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic start;    // search word taken, reset scan
    logic scan;
    logic load_out;
    logic shift;
    logic flush;
    logic front;
    logic swap_hi;
    logic swap_lo;
  } sols_cmd_t;

  typedef struct packed {
    logic done;       // scan finished, hit or miss
    logic found;
    logic h_zero;     // hit at position 0
    logic src_zero;   // last shift read issued
    logic mode_front;
    logic mode_swap;
    logic out_free;
  } sols_sts_t;

endpackage

[src/sols_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/sols_ctrl.sv]
// Sequencer for the list search: scan, result hand-off and reordering steps.
// Depends on sols_pkg for the command and status types.
module sols_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_search_i,
  output logic                in_stall_o,
  input  sols_pkg::sols_sts_t sts_i,
  output sols_pkg::sols_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_RESULT  = 3'd2;
  localparam logic [2:0] ST_SHIFT   = 3'd3;
  localparam logic [2:0] ST_FLUSH   = 3'd4;
  localparam logic [2:0] ST_FRONT   = 3'd5;
  localparam logic [2:0] ST_SWAP_HI = 3'd6;
  localparam logic [2:0] ST_SWAP_LO = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_search_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          priority if (sts_i.found && !sts_i.h_zero && sts_i.mode_front) begin
            state_d = ST_SHIFT;
          end else if (sts_i.found && !sts_i.h_zero && sts_i.mode_swap) begin
            state_d = ST_SWAP_HI;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.src_zero) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_FRONT;
      end
      ST_FRONT: begin
        cmd_o.front = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SWAP_HI: begin
        cmd_o.swap_hi = 1'b1;
        state_d       = ST_SWAP_LO;
      end
      ST_SWAP_LO: begin
        cmd_o.swap_lo = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[src/sols_dp.sv]
// Datapath of the list search: config registers, list RAM, scan counter,
// compare, shift/swap write steering and the result register.
// Depends on sols_pkg and sols_ram.
module sols_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sols_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sols_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_cmd_i,
  input  logic [sols_pkg::POS_W-1:0]           in_position_i,
  input  logic signed [sols_pkg::KEY_W-1:0]    in_key_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 out_found_o,
  output logic [sols_pkg::POS_W-1:0]           out_hit_position_o,
  input  sols_pkg::sols_cmd_t                  cmd_i,
  output sols_pkg::sols_sts_t                  sts_o
);

  logic [sols_pkg::CFG_DATA_W-1:0] len_q;
  logic [sols_pkg::MODE_W-1:0]     mode_q;
  logic [sols_pkg::KEY_W-1:0]      key_q;
  logic [sols_pkg::KEY_W-1:0]      prev_q;
  logic [sols_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            issue_q, issue_d;
  logic [sols_pkg::ADDR_W-1:0]     idx_q;
  logic [sols_pkg::ADDR_W-1:0]     hit_q;
  logic                            found_q;
  logic [sols_pkg::ADDR_W-1:0]     src_q;
  logic                            pend_q;
  logic [sols_pkg::ADDR_W-1:0]     pend_addr_q;
  logic                            out_valid_q;
  logic                            out_found_q;
  logic [sols_pkg::POS_W-1:0]      out_pos_q;

  logic [sols_pkg::LEN_W-1:0]      len_ext, len_eff;
  logic                            scan_end, match_v, done;
  logic                            pos_ok;
  logic                            ram_we;
  logic [sols_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [sols_pkg::KEY_W-1:0]      ram_wdata, ram_rdata;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= sols_pkg::LEN_RST;
      mode_q <= sols_pkg::MODE_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sols_pkg::REG_ACTIVE_LENGTH: len_q  <= cfg_data_i;
        sols_pkg::REG_REORDER_MODE:  mode_q <= cfg_data_i[sols_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to the list depth
  assign len_ext  = sols_pkg::LEN_W'(len_q);
  assign len_eff  = (len_ext > sols_pkg::LEN_W'(sols_pkg::LIST_DEPTH)) ?
                    sols_pkg::LEN_W'(sols_pkg::LIST_DEPTH) : len_ext;
  assign scan_end = (sols_pkg::LEN_W'(cnt_q) >= len_eff);
  assign match_v  = issue_q && (ram_rdata == key_q);
  assign done     = match_v || scan_end;
  assign pos_ok   = (32'(in_position_i) < 32'(sols_pkg::LIST_DEPTH));

  always_comb begin
    cnt_d   = cnt_q;
    issue_d = 1'b0;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (cmd_i.scan && !done) begin
      cnt_d   = cnt_q + sols_pkg::CNT_W'(1);
      issue_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      issue_q <= issue_d;
      pend_q  <= cmd_i.shift;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (cmd_i.start) begin
      key_q <= $unsigned(in_key_i);
    end
    if (issue_d) begin
      idx_q <= cnt_q[sols_pkg::ADDR_W-1:0];
    end
    // keep the entry before the current one for transposition
    if (cmd_i.scan && issue_q && !match_v) begin
      prev_q <= ram_rdata;
    end
    if (cmd_i.scan && done) begin
      found_q <= match_v;
      hit_q   <= match_v ? idx_q : '0;
    end
    if (cmd_i.load_out) begin
      out_found_q <= found_q;
      out_pos_q   <= sols_pkg::POS_W'(hit_q);
      src_q       <= hit_q - sols_pkg::ADDR_W'(1);
    end else if (cmd_i.shift) begin
      src_q <= src_q - sols_pkg::ADDR_W'(1);
    end
    if (cmd_i.shift) begin
      pend_addr_q <= src_q + sols_pkg::ADDR_W'(1);
    end
  end

  // shift: read src, write the word read last cycle one place up
  assign ram_raddr = cmd_i.shift ? src_q : cnt_q[sols_pkg::ADDR_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q;
    priority if (cmd_i.accept && (in_cmd_i == sols_pkg::CMD_WRITE) && pos_ok) begin
      ram_we    = 1'b1;
      ram_waddr = sols_pkg::ADDR_W'(in_position_i);
      ram_wdata = $unsigned(in_key_i);
    end else if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end else if (cmd_i.front) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = key_q;
    end else if (cmd_i.swap_hi) begin
      ram_we    = 1'b1;
      ram_waddr = hit_q;
      ram_wdata = prev_q;
    end else if (cmd_i.swap_lo) begin
      ram_we    = 1'b1;
      ram_waddr = hit_q - sols_pkg::ADDR_W'(1);
      ram_wdata = key_q;
    end else begin
      ram_we = 1'b0;
    end
  end

  sols_ram #(
    .WIDTH (sols_pkg::KEY_W),
    .DEPTH (sols_pkg::LIST_DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.done       = done;
  assign sts_o.found      = found_q;
  assign sts_o.h_zero     = (hit_q == '0);
  assign sts_o.src_zero   = (src_q == '0);
  assign sts_o.mode_front = (mode_q == sols_pkg::MODE_FRONT);
  assign sts_o.mode_swap  = (mode_q == sols_pkg::MODE_SWAP);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign out_found_o        = out_found_q;
  assign out_hit_position_o = out_pos_q;

endmodule

[src/self_organizing_list_search.sv]
// Top level of the self-organising list search: controller plus datapath.
// Depends on sols_pkg, sols_ctrl, sols_dp and assert_macros.svh.
//
//  word     direction  handshake             payload
//  in       to block   in_valid_i/in_stall_o  in_cmd_i, in_position_i, in_key_i
//  out      from block out_valid_o/out_stall_i out_found_o, out_hit_position_o
//  cfg      to block   cfg_we_i               cfg_index_i, cfg_data_i
//
// A search scans one entry a cycle through the single read port of the list
// RAM, then loads the result register. Move-to-front then moves the entries
// before the hit up one place and writes the key at position 0; transposition
// swaps the hit with the entry before it. The result register lets a waiting
// result sit under out_stall_i while the next word is taken; a search
// finishing behind a stalled result holds until the register frees.
// After reset the list contents are undefined until written; no clearing pass.
`include "assert_macros.svh"

module self_organizing_list_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sols_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sols_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               in_cmd_i,
  input  logic [sols_pkg::POS_W-1:0]         in_position_i,
  input  logic signed [sols_pkg::KEY_W-1:0]  in_key_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               out_found_o,
  output logic [sols_pkg::POS_W-1:0]         out_hit_position_o
);

  sols_pkg::sols_cmd_t cmd;
  sols_pkg::sols_sts_t sts;
  logic                search_taken;
  logic [7:0]          step_cmds;

  sols_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_search_i (in_cmd_i == sols_pkg::CMD_SEARCH),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sols_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_cmd_i           (in_cmd_i),
    .in_position_i      (in_position_i),
    .in_key_i           (in_key_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_found_o        (out_found_o),
    .out_hit_position_o (out_hit_position_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

  assign search_taken = in_valid_i && !in_stall_o && (in_cmd_i == sols_pkg::CMD_SEARCH);
  assign step_cmds    = {cmd.start, cmd.scan, cmd.load_out, cmd.shift,
                         cmd.flush, cmd.front, cmd.swap_hi, cmd.swap_lo};

  `SOLS_ASSERT(a_one_step, $onehot0(step_cmds))
  `SOLS_ASSERT(a_load_free, cmd.load_out |-> sts.out_free)
  `SOLS_ASSERT(a_search_scans, search_taken |=> cmd.scan)
  `SOLS_NEVER(a_no_take_busy, cmd.scan && !in_stall_o)

endmodule
